### design/ipl_pkg.sv
// Package for the interpolated profile lookup block.
// Holds sizes, the row record, the controller state type and the command and status structs.
// No dependencies.
package ipl_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int FRACTION_BITS = 16;

    localparam int ANG_W  = 16;                       // Q4.12 field width
    localparam int ROW_W  = 6;                        // row_index field width
    localparam int CFG_W  = 7;                        // entry_count register width
    localparam int TABLE_AW = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int WIDE_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int DIFF_W = ANG_W + 1;                // difference of two Q4.12 values
    localparam int FRAC_W = FRACTION_BITS + 1;        // fraction runs 0 .. 2^FRACTION_BITS
    localparam int STEP_W = $clog2(FRAC_W);
    localparam int PROD_W = FRAC_W + 1 + DIFF_W;

    typedef struct packed {
        logic signed [ANG_W-1:0] angle;
        logic signed [ANG_W-1:0] drag;
        logic signed [ANG_W-1:0] lift;
    } t_ipl_row;

    typedef struct packed {
        logic signed [ANG_W-1:0] drag;
        logic signed [ANG_W-1:0] lift;
    } t_ipl_coef;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRIME,
        S_SCAN,
        S_DIV,
        S_MUL_D,
        S_MUL_L,
        S_RES
    } t_ipl_state;

    typedef struct packed {
        logic write_row;
        logic accept_query;
        logic adv;
        logic shift_prev;
        logic bracket;
        logic div_step;
        logic mul_drag;
        logic mul_lift;
        logic load_out;
    } t_ipl_cmd;

    typedef struct packed {
        logic hit;
        logic last;
        logic interp;
    } t_ipl_sts;

endpackage

### design/ipl_ctrl.sv
// Controller for the interpolated profile lookup block.
// Sequences scan, division, multiplies and result hand-off; depends on ipl_pkg.
module ipl_ctrl
    import ipl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_opcode,
    input  logic     i_stall,
    input  t_ipl_sts i_sts,
    output t_ipl_cmd o_cmd,
    output logic     o_stall,
    output logic     o_valid
);

    t_ipl_state r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic r_out_vld, n_out_vld;
    logic out_free;
    logic scan_done;

    assign out_free  = !r_out_vld || !i_stall;
    assign scan_done = i_sts.hit || i_sts.last;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_valid && i_opcode) n_state = S_PRIME;
            S_PRIME: n_state = S_SCAN;
            S_SCAN: begin
                if (scan_done) n_state = i_sts.interp ? S_DIV : S_MUL_D;
            end
            S_DIV:   if (r_step == STEP_W'(FRACTION_BITS)) n_state = S_MUL_D;
            S_MUL_D: n_state = S_MUL_L;
            S_MUL_L: n_state = S_RES;
            S_RES:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.write_row    = i_valid && !i_opcode;
                o_cmd.accept_query = i_valid && i_opcode;
            end
            S_PRIME: o_cmd.adv = 1'b1;
            S_SCAN: begin
                o_cmd.adv        = 1'b1;
                o_cmd.shift_prev = !scan_done;
                o_cmd.bracket    = scan_done;
            end
            S_DIV:   o_cmd.div_step = 1'b1;
            S_MUL_D: o_cmd.mul_drag = 1'b1;
            S_MUL_L: o_cmd.mul_lift = 1'b1;
            S_RES:   o_cmd.load_out = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (r_state == S_SCAN) begin
            n_step = '0;
        end else if (r_state == S_DIV) begin
            n_step = r_step + 1'b1;
        end
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_vld = 1'b1;
        end else begin
            n_out_vld = r_out_vld && i_stall;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;

endmodule

### design/ipl_dp.sv
// Datapath for the interpolated profile lookup block: row memory, scan compare,
// restoring divider, shared multiplier and result registers; depends on ipl_pkg.
module ipl_dp
    import ipl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ipl_cmd                i_cmd,
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic [ROW_W-1:0]        i_row_index,
    input  logic signed [ANG_W-1:0] i_row_angle,
    input  logic signed [ANG_W-1:0] i_row_drag,
    input  logic signed [ANG_W-1:0] i_row_lift,
    input  logic signed [ANG_W-1:0] i_query_angle,
    output t_ipl_sts                o_sts,
    output logic signed [ANG_W-1:0] o_drag_coeff,
    output logic signed [ANG_W-1:0] o_lift_coeff
);

    t_ipl_row r_mem [TABLE_DEPTH];
    t_ipl_row r_rd_data;
    t_ipl_row r_prev;
    t_ipl_coef r_c1, r_c2;

    logic [CFG_W-1:0]        r_entry_count;
    logic [TABLE_AW-1:0]     r_ptr, r_rd_idx, r_last_idx;
    logic signed [ANG_W-1:0] r_q;
    logic [DIFF_W-1:0]       r_rem, r_den;
    logic [FRAC_W-1:0]       r_frac;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ANG_W-1:0] r_drag_res;
    logic signed [ANG_W-1:0] r_out_drag, r_out_lift;

    logic [WIDE_W-1:0]       row_w, cnt_w, last_w;
    logic                    row_ok;
    logic signed [DIFF_W-1:0] num_s, den_s, d_drag, d_lift, d_sel;
    logic                    ge;
    logic [DIFF_W-1:0]       rem_diff;
    logic signed [FRAC_W:0]  mul_a;
    logic signed [PROD_W-1:0] mul_p;

    assign row_w  = WIDE_W'(i_row_index);
    assign row_ok = row_w < WIDE_W'(TABLE_DEPTH);
    assign cnt_w  = WIDE_W'(r_entry_count);

    // clamp the row count to 1 .. TABLE_DEPTH
    always_comb begin
        priority if (cnt_w == '0) begin
            last_w = '0;
        end else if (cnt_w > WIDE_W'(TABLE_DEPTH)) begin
            last_w = WIDE_W'(TABLE_DEPTH - 1);
        end else begin
            last_w = cnt_w - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= CFG_W'(1);
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_row && row_ok) begin
            r_mem[row_w[TABLE_AW-1:0]] <= '{angle: i_row_angle, drag: i_row_drag,
                                            lift: i_row_lift};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_ptr];
        r_rd_idx  <= r_ptr;
    end

    assign o_sts.hit    = r_rd_data.angle >= r_q;
    assign o_sts.last   = r_rd_idx == r_last_idx;
    assign o_sts.interp = o_sts.hit && (r_rd_idx != '0);

    assign num_s  = DIFF_W'(r_q) - DIFF_W'(r_prev.angle);
    assign den_s  = DIFF_W'(r_rd_data.angle) - DIFF_W'(r_prev.angle);
    assign d_drag = DIFF_W'(r_c2.drag) - DIFF_W'(r_c1.drag);
    assign d_lift = DIFF_W'(r_c2.lift) - DIFF_W'(r_c1.lift);
    assign d_sel  = i_cmd.mul_lift ? d_lift : d_drag;

    assign ge       = r_rem >= r_den;
    assign rem_diff = ge ? (r_rem - r_den) : r_rem;

    // full-width signed product of the fraction and the coefficient step
    assign mul_a = signed'({1'b0, r_frac});
    assign mul_p = mul_a * d_sel;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_query) begin
            r_q        <= i_query_angle;
            r_last_idx <= last_w[TABLE_AW-1:0];
            r_ptr      <= '0;
        end else if (i_cmd.adv) begin
            r_ptr <= r_ptr + 1'b1;
        end

        if (i_cmd.shift_prev) begin
            r_prev <= r_rd_data;
        end

        if (i_cmd.bracket) begin
            r_frac <= '0;
            r_c2   <= '{drag: r_rd_data.drag, lift: r_rd_data.lift};
            if (o_sts.interp) begin
                r_c1  <= '{drag: r_prev.drag, lift: r_prev.lift};
                r_rem <= num_s;
                r_den <= den_s;
            end else begin
                r_c1 <= '{drag: r_rd_data.drag, lift: r_rd_data.lift};
            end
        end else if (i_cmd.div_step) begin
            r_rem  <= {rem_diff[DIFF_W-2:0], 1'b0};
            r_frac <= {r_frac[FRAC_W-2:0], ge};
        end

        if (i_cmd.mul_drag || i_cmd.mul_lift) begin
            r_prod <= mul_p;
        end
        if (i_cmd.mul_lift) begin
            r_drag_res <= ANG_W'(r_c1.drag + r_prod[FRACTION_BITS +: ANG_W]);
        end
        if (i_cmd.load_out) begin
            r_out_drag <= r_drag_res;
            r_out_lift <= ANG_W'(r_c1.lift + r_prod[FRACTION_BITS +: ANG_W]);
        end
    end

    assign o_drag_coeff = r_out_drag;
    assign o_lift_coeff = r_out_lift;

endmodule

### design/interpolated_profile_lookup_core.sv
// Top level of the interpolated profile lookup block.
// Joins the controller ipl_ctrl and the datapath ipl_dp; depends on ipl_pkg.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one item per transfer. Opcode 0
//   writes a row (angle, drag, lift) into the 64-row table; opcode 1 queries
//   the drag and lift coefficients at i_query_angle.
//   Output channel (o_valid / i_stall) carries one result per query; writes
//   produce nothing.
//   i_cfg_we / i_cfg_data load the number of rows in use (reset value 1).
//   Change it only while the block is idle.
// Timing:
//   A write leaves the block idle; the next item is taken in the following cycle.
//   A query scans the table one row per cycle until it meets a row whose angle
//   is not below the query angle or reaches the last row in use. A query that
//   interpolates then runs the 17-step restoring divider; a query that clamps
//   to an end row skips it. Every query then makes two passes through one
//   shared multiplier before its result is handed off.
// Reset:
//   Synchronous, active low. Clears the controller and the output valid and
//   sets the row count to 1; table contents are kept and are undefined
//   until written.
// Back-pressure:
//   A finished result waits in the output register while i_stall is high;
//   meanwhile the block keeps taking writes and works on the next query,
//   holding that query's result until the output register frees up.
module interpolated_profile_lookup_core
    import ipl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_W-1:0]        i_cfg_data,
    // input channel
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_opcode,
    input  logic [ROW_W-1:0]        i_row_index,
    input  logic signed [ANG_W-1:0] i_row_angle,
    input  logic signed [ANG_W-1:0] i_row_drag,
    input  logic signed [ANG_W-1:0] i_row_lift,
    input  logic signed [ANG_W-1:0] i_query_angle,
    // output channel
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [ANG_W-1:0] o_drag_coeff,
    output logic signed [ANG_W-1:0] o_lift_coeff
);

    t_ipl_cmd cmd;
    t_ipl_sts sts;

    // sequencing: accept, scan, divide, multiply, hand off
    ipl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_opcode (i_opcode),
        .i_stall  (i_stall),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    // table, arithmetic and result registers
    ipl_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_row_index   (i_row_index),
        .i_row_angle   (i_row_angle),
        .i_row_drag    (i_row_drag),
        .i_row_lift    (i_row_lift),
        .i_query_angle (i_query_angle),
        .o_sts         (sts),
        .o_drag_coeff  (o_drag_coeff),
        .o_lift_coeff  (o_lift_coeff)
    );

endmodule

### design/ipl_chk.sv
// Port-level checker for the interpolated profile lookup block, bound to the top level.
// Depends on ipl_pkg.
module ipl_chk
    import ipl_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic                    i_opcode,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [ANG_W-1:0] o_drag_coeff,
    input logic signed [ANG_W-1:0] o_lift_coeff
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drag_coeff) && $stable(o_lift_coeff))
        else $error("stalled result changed or dropped");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a query transfer starts the busy sequence
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_opcode |=> o_stall)
        else $error("query taken without going busy");

    // a row write does not leave the block busy
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !i_opcode |=> !o_stall)
        else $error("row write left the block busy");

    // a new result only ever comes out of a query in progress
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared without a query in progress");

endmodule

bind interpolated_profile_lookup_core ipl_chk u_ipl_chk (.*);

### test/tb_interpolated_profile_lookup_core.sv
// Self-checking testbench for interpolated_profile_lookup_core: row loads, clamped and
// interpolated queries under random idling and back-pressure, across several row counts.
// Depends on ipl_pkg and the core RTL; needs no files or arguments.
module tb_interpolated_profile_lookup_core;
    import ipl_pkg::*;

    localparam logic OP_WRITE_ROW = 1'b0;
    localparam logic OP_QUERY     = 1'b1;

    localparam int RANDOM_ITEMS     = 1800;
    localparam int ITEMS_PER_PHASE  = 60;
    localparam int SETTLE_CYCLES    = 100;     // longer than the slowest query
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int DRAIN_LIMIT      = 20000;
    localparam int TIMEOUT_CYCLES   = 1200000;

    // Golden table, row count and the queue of coefficients still owed by the core.
    class profile_lookup_sb;
        logic signed [ANG_W-1:0] angle_tab [TABLE_DEPTH];
        logic signed [ANG_W-1:0] drag_tab  [TABLE_DEPTH];
        logic signed [ANG_W-1:0] lift_tab  [TABLE_DEPTH];
        logic [CFG_W-1:0]        row_count = 1;
        t_ipl_coef               pending_coeffs [$];
        int                      n_writes, n_queries, n_checked, n_errors;

        // c1 + floor(frac * (c2 - c1) / 2^FRACTION_BITS), kept to 16 bits
        function logic signed [ANG_W-1:0] blend(logic signed [ANG_W-1:0] c1,
                                                logic signed [ANG_W-1:0] c2,
                                                longint frac);
            longint d, p, s;
            d = longint'(c2) - longint'(c1);
            p = frac * d;
            s = longint'(c1) + (p >>> FRACTION_BITS);
            return s[ANG_W-1:0];
        endfunction

        function t_ipl_coef lookup_coeffs(logic signed [ANG_W-1:0] q);
            int        n, lo, hi;
            longint    num, den, frac;
            t_ipl_coef c;
            n = row_count;
            if (n == 0) n = 1;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            // first row whose angle is not below the query
            hi = 0;
            if (n > 1)
                while (hi < n && angle_tab[hi] < q) hi++;
            frac = 0;
            if (n == 1 || hi == 0) begin
                lo = 0;
                hi = 0;
            end else if (hi == n) begin
                lo = n - 1;
                hi = n - 1;
            end else begin
                lo  = hi - 1;
                num = longint'(q) - longint'(angle_tab[lo]);
                den = longint'(angle_tab[hi]) - longint'(angle_tab[lo]);
                if (den > 0 && num >= 0)
                    frac = (num << FRACTION_BITS) / den;
            end
            c.drag = blend(drag_tab[lo], drag_tab[hi], frac);
            c.lift = blend(lift_tab[lo], lift_tab[hi], frac);
            return c;
        endfunction

        function void note_item(logic op, logic [ROW_W-1:0] row,
                                logic signed [ANG_W-1:0] ang, logic signed [ANG_W-1:0] drg,
                                logic signed [ANG_W-1:0] lft, logic signed [ANG_W-1:0] qa);
            if (op == OP_WRITE_ROW) begin
                angle_tab[row] = ang;
                drag_tab[row]  = drg;
                lift_tab[row]  = lft;
                n_writes++;
            end else begin
                pending_coeffs.push_back(lookup_coeffs(qa));
                n_queries++;
            end
        endfunction

        function void check_coeffs(logic signed [ANG_W-1:0] drg, logic signed [ANG_W-1:0] lft);
            t_ipl_coef e;
            if (pending_coeffs.size() == 0) begin
                $error("unexpected result: drag_coeff %0d lift_coeff %0d", drg, lft);
                n_errors++;
                return;
            end
            e = pending_coeffs.pop_front();
            n_checked++;
            if (drg !== e.drag) begin
                $error("drag_coeff: expected %0d, actual %0d", e.drag, drg);
                n_errors++;
            end
            if (lft !== e.lift) begin
                $error("lift_coeff: expected %0d, actual %0d", e.lift, lft);
                n_errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_opcode = OP_WRITE_ROW;
    logic [ROW_W-1:0]        i_row_index = '0;
    logic signed [ANG_W-1:0] i_row_angle = '0;
    logic signed [ANG_W-1:0] i_row_drag = '0;
    logic signed [ANG_W-1:0] i_row_lift = '0;
    logic signed [ANG_W-1:0] i_query_angle = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [ANG_W-1:0] o_drag_coeff;
    logic signed [ANG_W-1:0] o_lift_coeff;

    profile_lookup_sb sb;
    int               cur_rows = 1;      // rows the core scans under the current count
    int               n_sent;
    int               n_settings;
    bit               no_idle;           // phase runs both sides back to back
    bit               hold_off_req;      // ask the receiver for one long stall

    interpolated_profile_lookup_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_row_index   (i_row_index),
        .i_row_angle   (i_row_angle),
        .i_row_drag    (i_row_drag),
        .i_row_lift    (i_row_lift),
        .i_query_angle (i_query_angle),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drag_coeff  (o_drag_coeff),
        .o_lift_coeff  (o_lift_coeff)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Watch both channels and the config port at every edge; all inputs change by
    // nonblocking assignment, so values seen here are the ones the core sampled.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sb.row_count = 1;
        end else begin
            if (i_cfg_we)
                sb.row_count = i_cfg_data;
            if (i_valid && !o_stall)
                sb.note_item(i_opcode, i_row_index, i_row_angle, i_row_drag, i_row_lift,
                             i_query_angle);
            if (o_valid && !i_stall)
                sb.check_coeffs(o_drag_coeff, o_lift_coeff);
        end
    end

    // Receiver: stall a random number of cycles before each result, or hold off
    // for a long stretch when asked, then wait for the transfer.
    initial begin
        int stall_len;
        forever begin
            if (hold_off_req) begin
                stall_len    = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                stall_len = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (stall_len > 0) begin
                i_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        #(12 * TIMEOUT_CYCLES);
        $display("interpolated_profile_lookup_core test failed");
        $finish;
    end

    // Offer one item after a random gap and hold it until the core takes it.
    // Valid stays high when the next item follows without a gap.
    task automatic send_item(logic op, logic [ROW_W-1:0] row, logic signed [ANG_W-1:0] ang,
                             logic signed [ANG_W-1:0] drg, logic signed [ANG_W-1:0] lft,
                             logic signed [ANG_W-1:0] qa);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_row_index   <= row;
        i_row_angle   <= ang;
        i_row_drag    <= drg;
        i_row_lift    <= lft;
        i_query_angle <= qa;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
    endtask

    // Row write; the unused query field carries noise.
    task automatic write_row(logic [ROW_W-1:0] row, logic signed [ANG_W-1:0] ang,
                             logic signed [ANG_W-1:0] drg, logic signed [ANG_W-1:0] lft);
        send_item(OP_WRITE_ROW, row, ang, drg, lft, 16'($urandom()));
    endtask

    // Query; the unused row fields carry noise.
    task automatic query(logic signed [ANG_W-1:0] qa);
        send_item(OP_QUERY, 6'($urandom()), 16'($urandom()), 16'($urandom()),
                  16'($urandom()), qa);
    endtask

    // Drain every owed result, let the core settle, then load a new row count.
    task automatic set_row_count(logic [CFG_W-1:0] v);
        i_valid <= 1'b0;
        while (sb.pending_coeffs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_rows = (v == 0) ? 1 : (v > TABLE_DEPTH) ? TABLE_DEPTH : int'(v);
        n_settings++;
    endtask

    function automatic logic signed [ANG_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return 16'($urandom());
        endcase
    endfunction

    // Load rows 0..n-1 with strictly rising angles: either spread over the full
    // range or from a random base with random steps, sometimes tiny ones.
    task automatic load_rows(int n);
        int  a, base, lim, smax;
        bit  full_span;
        full_span = (n > 1) && ($urandom_range(0, 3) == 0);
        base = -32768 + int'($urandom_range(0, 32768));
        lim  = (32767 - base) / n;
        smax = ($urandom_range(0, 2) == 0 && lim > 4) ? 4 : lim;
        a    = base;
        for (int i = 0; i < n; i++) begin
            if (full_span)
                a = -32768 + (i * 65535) / (n - 1);
            write_row(i[ROW_W-1:0], a[ANG_W-1:0], rand_coef(), rand_coef());
            a += int'($urandom_range(1, smax));
        end
    endtask

    // Query angle: mostly inside the loaded span, some on or next to a row
    // angle, some anywhere in the 16-bit range.
    function automatic logic signed [ANG_W-1:0] pick_query();
        int lo_a, hi_a, t, r;
        lo_a = sb.angle_tab[0];
        hi_a = sb.angle_tab[cur_rows-1];
        if (lo_a > hi_a) begin
            t    = lo_a;
            lo_a = hi_a;
            hi_a = t;
        end
        r = $urandom_range(0, cur_rows - 1);
        case ($urandom_range(0, 9))
            0: return 16'($urandom());
            1: return sb.angle_tab[r];
            2: begin
                t = int'(sb.angle_tab[r]) + ($urandom_range(0, 1) ? 1 : -1);
                if (t > 32767) t = 32767;
                if (t < -32768) t = -32768;
                return t[ANG_W-1:0];
            end
            default: begin
                t = lo_a + int'($urandom_range(0, hi_a - lo_a));
                return t[ANG_W-1:0];
            end
        endcase
    endfunction

    initial begin
        int unsigned fixed_counts [6] = '{64, 0, 127, 65, 2, 1};
        int          phase;
        int          drain;
        logic [CFG_W-1:0] cnt;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // One-row table at the reset count: every query returns row 0.
        no_idle = 1'b0;
        write_row(0, 16'sd0, 16'sh7fff, 16'sh8000);
        query(16'sh8000);
        query(16'sh7fff);
        query(16'sd0);

        // Four rows spanning the whole angle range with extreme coefficients.
        set_row_count(4);
        write_row(0, 16'sh8000, 16'sh8000, 16'sh7fff);
        write_row(1, -16'sd1, 16'sh7fff, 16'sh8000);
        write_row(2, 16'sd0, 16'sd0, 16'sd1);
        write_row(3, 16'sh7fff, 16'sh7fff, 16'sh8000);
        query(16'sh8000);           // at the first angle
        query(-16'sd32767);         // just above the first angle, tiny fraction
        query(-16'sd2);             // wide bracket, fraction near one
        query(-16'sd1);             // exactly on a row, full fraction
        query(16'sd1);
        query(16'sd16384);
        query(16'sh7fff);           // exactly on the last angle
        write_row(3, 16'sd32000, 16'sh8000, 16'sh7fff);
        query(16'sh7fff);           // above the last angle
        write_row(2, -16'sd5000, 16'sd100, -16'sd100);  // angles no longer rising
        query(16'sd0);

        // Random phases, each under a fresh row count and a freshly loaded table.
        phase = 0;
        while (n_sent < RANDOM_ITEMS) begin
            if (phase < 6)
                cnt = CFG_W'(fixed_counts[phase]);
            else if ($urandom_range(0, 4) == 0)
                cnt = CFG_W'($urandom_range(17, TABLE_DEPTH));
            else
                cnt = CFG_W'($urandom_range(2, 16));
            set_row_count(cnt);
            no_idle = ($urandom_range(0, 3) == 0);
            load_rows(cur_rows);
            // Stall the output for a long stretch on a short table so queries pile up.
            if (phase == 4)
                hold_off_req = 1'b1;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(0, 4) == 0)
                    write_row(6'($urandom()), 16'($urandom()), rand_coef(), rand_coef());
                else
                    query(pick_query());
            end
            phase++;
        end

        i_valid <= 1'b0;
        drain = 0;
        while (sb.pending_coeffs.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending_coeffs.size() != 0) begin
            $error("%0d results never arrived", sb.pending_coeffs.size());
            sb.n_errors++;
        end

        $display("Ran %0d row writes and %0d queries over %0d row-count settings,",
                 sb.n_writes, sb.n_queries, n_settings);
        $display("including counts 0, 1, 64 and 127; %0d results compared, %0d errors.",
                 sb.n_checked, sb.n_errors);
        if (sb.n_errors == 0)
            $display("interpolated_profile_lookup_core test passed");
        else
            $display("interpolated_profile_lookup_core test failed");
        $finish;
    end

endmodule

### files.f
design/ipl_pkg.sv
design/ipl_ctrl.sv
design/ipl_dp.sv
design/interpolated_profile_lookup_core.sv
design/ipl_chk.sv
test/tb_interpolated_profile_lookup_core.sv
